>>> hdl/rau_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Shared constants, operation codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package rau_pkg;

  // Default operand width (numerators and denominators)
  localparam int OPERAND_WIDTH_DEF = 16;

  // Fixed result field widths
  localparam int NUM_W = 33;
  localparam int DEN_W = 31;
  localparam int CMD_W = 2;

  // Operation codes carried by the cmd field
  typedef enum logic [CMD_W-1:0] {
    CMD_MUL = 2'd0,
    CMD_ADD = 2'd1,
    CMD_SUB = 2'd2,
    CMD_DIV = 2'd3
  } cmd_t;

  // Datapath operation issued by the controller each cycle
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_N,
    OP_MUL_D,
    OP_MUL_T,
    OP_SUM,
    OP_GCD,
    OP_GLOAD,
    OP_DIV,
    OP_OUT
  } dp_op_t;

  // Datapath status back to the controller
  typedef struct packed {
    logic err;       // zero denominator or divide by zero
    logic addsub;    // item is an add or subtract
    logic gcd_done;  // GCD working value reached zero
  } dp_stat_t;

endpackage
`default_nettype wire

>>> hdl/rau_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Rational arithmetic datapath
// Operand latch, shared multiplier, signed add, binary GCD and a dual
// restoring divider that reduces numerator and denominator by the GCD.
// ----------------------------------------------------------------------------
module rau_dpath #(
  parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire rau_pkg::dp_op_t            op,
  input  wire logic [rau_pkg::CMD_W-1:0]  cmd,
  input  wire logic [OPERAND_WIDTH-1:0]   num_a,
  input  wire logic [OPERAND_WIDTH-1:0]   den_a,
  input  wire logic [OPERAND_WIDTH-1:0]   num_b,
  input  wire logic [OPERAND_WIDTH-1:0]   den_b,
  output rau_pkg::dp_stat_t               stat,
  output logic [rau_pkg::NUM_W-1:0]       res_num,
  output logic [rau_pkg::DEN_W-1:0]       res_den,
  output logic                            div_zero
);

  localparam int W  = OPERAND_WIDTH;
  localparam int MW = 2 * OPERAND_WIDTH;
  localparam int KW = $clog2(MW);
  localparam int XW = (MW > rau_pkg::NUM_W) ? MW : rau_pkg::NUM_W;

  // Latched operands in sign/magnitude form
  rau_pkg::cmd_t  cmd_r;
  logic           na_neg, da_neg, nb_neg, db_neg;
  logic [W-1:0]   na_mag, da_mag, nb_mag, db_mag;

  // Products: numerator term, denominator, second numerator term
  logic [MW-1:0]  pn_mag, pd_mag, pt_mag;
  logic           pn_neg, pd_neg, pt_neg;

  // Reduction state
  logic [MW-1:0]  n_mag, d_mag;
  logic           neg_r;
  logic [MW-1:0]  ga, gb, g;
  logic [KW-1:0]  k;
  logic [MW-1:0]  rn, rd, qn, qd;

  // Multiplier operand selection
  logic [W-1:0]   ma, mb;
  logic           sa, sb;
  logic [MW-1:0]  prod;
  logic           prod_neg;

  always_comb begin
    case (op)
      rau_pkg::OP_MUL_D: begin
        ma = da_mag;
        sa = da_neg;
        mb = (cmd_r == rau_pkg::CMD_DIV) ? nb_mag : db_mag;
        sb = (cmd_r == rau_pkg::CMD_DIV) ? nb_neg : db_neg;
      end
      rau_pkg::OP_MUL_T: begin
        ma = nb_mag;
        sa = nb_neg;
        mb = da_mag;
        sb = da_neg;
      end
      default: begin
        ma = na_mag;
        sa = na_neg;
        mb = (cmd_r == rau_pkg::CMD_MUL) ? nb_mag : db_mag;
        sb = (cmd_r == rau_pkg::CMD_MUL) ? nb_neg : db_neg;
      end
    endcase
  end

  assign prod     = MW'(ma) * MW'(mb);
  assign prod_neg = (sa ^ sb) && (prod != '0);

  // Signed add of the two numerator terms (second term negated for subtract)
  logic           addsub, t_neg, s_neg, nn_neg;
  logic [MW-1:0]  s_mag, nn_mag;

  assign addsub = (cmd_r == rau_pkg::CMD_ADD) || (cmd_r == rau_pkg::CMD_SUB);
  assign t_neg  = pt_neg ^ ((cmd_r == rau_pkg::CMD_SUB) && (pt_mag != '0));

  always_comb begin
    if (pn_neg == t_neg) begin
      s_mag = pn_mag + pt_mag;
      s_neg = pn_neg;
    end else if (pn_mag >= pt_mag) begin
      s_mag = pn_mag - pt_mag;
      s_neg = pn_neg;
    end else begin
      s_mag = pt_mag - pn_mag;
      s_neg = t_neg;
    end
    nn_mag = addsub ? s_mag : pn_mag;
    nn_neg = addsub ? (s_neg && (s_mag != '0)) : pn_neg;
  end

  // One binary GCD step
  logic [MW-1:0]  ga_next, gb_next, gdiff;
  logic [KW-1:0]  k_next;
  logic           g_ge;

  assign g_ge  = ga >= gb;
  assign gdiff = g_ge ? (ga - gb) : (gb - ga);

  always_comb begin
    ga_next = ga;
    gb_next = gb;
    k_next  = k;
    case ({ga[0], gb[0]})
      2'b00: begin
        ga_next = ga >> 1;
        gb_next = gb >> 1;
        k_next  = k + KW'(1);
      end
      2'b01: ga_next = ga >> 1;
      2'b10: gb_next = gb >> 1;
      default: begin
        if (g_ge) begin
          ga_next = gdiff >> 1;
        end else begin
          gb_next = gdiff >> 1;
        end
      end
    endcase
  end

  // One restoring division step on both quotients
  logic [MW:0]    tn, td, gx;
  logic           tn_ge, td_ge;

  assign gx    = {1'b0, g};
  assign tn    = {rn, qn[MW-1]};
  assign td    = {rd, qd[MW-1]};
  assign tn_ge = tn >= gx;
  assign td_ge = td >= gx;

  // Result formatting
  logic [XW-1:0]  qn_x, qd_x, num_x;

  assign qn_x  = XW'(qn);
  assign qd_x  = XW'(qd);
  assign num_x = neg_r ? (~qn_x + XW'(1)) : qn_x;

  // Sequential datapath
  always_ff @(posedge clk) begin
    case (op)
      rau_pkg::OP_LOAD: begin
        cmd_r  <= rau_pkg::cmd_t'(cmd);
        na_neg <= num_a[W-1];
        da_neg <= den_a[W-1];
        nb_neg <= num_b[W-1];
        db_neg <= den_b[W-1];
        na_mag <= num_a[W-1] ? (~num_a + W'(1)) : num_a;
        da_mag <= den_a[W-1] ? (~den_a + W'(1)) : den_a;
        nb_mag <= num_b[W-1] ? (~num_b + W'(1)) : num_b;
        db_mag <= den_b[W-1] ? (~den_b + W'(1)) : den_b;
      end
      rau_pkg::OP_MUL_N: begin
        pn_mag <= prod;
        pn_neg <= prod_neg;
        pt_mag <= '0;
        pt_neg <= 1'b0;
      end
      rau_pkg::OP_MUL_D: begin
        pd_mag <= prod;
        pd_neg <= prod_neg;
      end
      rau_pkg::OP_MUL_T: begin
        pt_mag <= prod;
        pt_neg <= prod_neg;
      end
      rau_pkg::OP_SUM: begin
        n_mag <= nn_mag;
        d_mag <= pd_mag;
        neg_r <= (nn_neg ^ pd_neg) && (nn_mag != '0);
        ga    <= nn_mag;
        gb    <= pd_mag;
        k     <= '0;
      end
      rau_pkg::OP_GCD: begin
        ga <= ga_next;
        gb <= gb_next;
        k  <= k_next;
      end
      rau_pkg::OP_GLOAD: begin
        g  <= gb << k;
        rn <= '0;
        rd <= '0;
        qn <= n_mag;
        qd <= d_mag;
      end
      rau_pkg::OP_DIV: begin
        rn <= tn_ge ? MW'(tn - gx) : tn[MW-1:0];
        rd <= td_ge ? MW'(td - gx) : td[MW-1:0];
        qn <= {qn[MW-2:0], tn_ge};
        qd <= {qd[MW-2:0], td_ge};
      end
      rau_pkg::OP_OUT: begin
        div_zero <= stat.err;
        res_num  <= stat.err ? '0 : num_x[rau_pkg::NUM_W-1:0];
        res_den  <= stat.err ? rau_pkg::DEN_W'(1) : qd_x[rau_pkg::DEN_W-1:0];
      end
      default: ;
    endcase
  end

  // Status to controller
  assign stat.err      = (da_mag == '0) || (db_mag == '0) ||
                         ((cmd_r == rau_pkg::CMD_DIV) && (nb_mag == '0));
  assign stat.addsub   = addsub;
  assign stat.gcd_done = (ga == '0);

  // The GCD partner value never reaches zero while iterating
  a_gcd_gb_nonzero: assert property (@(posedge clk) disable iff (rst)
    (op == rau_pkg::OP_GCD) |-> (gb != '0))
    else $error("GCD working value gb is zero");

  // The divisor handed to the divider is never zero
  a_divisor_nonzero: assert property (@(posedge clk) disable iff (rst)
    (op == rau_pkg::OP_GLOAD) |=> (g != '0))
    else $error("GCD result is zero");

endmodule
`default_nettype wire

>>> hdl/rau_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Rational arithmetic controller
// Sequences products, sum, GCD and division for one item at a time and
// owns the output valid flag.
// ----------------------------------------------------------------------------
module rau_ctrl #(
  parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  input  wire rau_pkg::dp_stat_t  stat,
  output rau_pkg::dp_op_t         op
);

  localparam int MW = 2 * OPERAND_WIDTH;
  localparam int CW = $clog2(MW);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_N,
    S_MUL_D,
    S_MUL_T,
    S_SUM,
    S_GCD,
    S_DIV,
    S_DONE
  } state_t;

  state_t         state, state_next;
  logic [CW-1:0]  cnt, cnt_next;
  logic           out_load;

  // Next state and datapath command
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    op         = rau_pkg::OP_NONE;
    out_load   = 1'b0;
    s_tready   = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          op         = rau_pkg::OP_LOAD;
          state_next = S_MUL_N;
        end
      end
      S_MUL_N: begin
        if (stat.err) begin
          state_next = S_DONE;
        end else begin
          op         = rau_pkg::OP_MUL_N;
          state_next = S_MUL_D;
        end
      end
      S_MUL_D: begin
        op         = rau_pkg::OP_MUL_D;
        state_next = stat.addsub ? S_MUL_T : S_SUM;
      end
      S_MUL_T: begin
        op         = rau_pkg::OP_MUL_T;
        state_next = S_SUM;
      end
      S_SUM: begin
        op         = rau_pkg::OP_SUM;
        state_next = S_GCD;
      end
      S_GCD: begin
        if (stat.gcd_done) begin
          op         = rau_pkg::OP_GLOAD;
          cnt_next   = CW'(MW - 1);
          state_next = S_DIV;
        end else begin
          op = rau_pkg::OP_GCD;
        end
      end
      S_DIV: begin
        op = rau_pkg::OP_DIV;
        if (cnt == '0) begin
          state_next = S_DONE;
        end else begin
          cnt_next = cnt - CW'(1);
        end
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          op         = rau_pkg::OP_OUT;
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State, counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Only one item in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second item accepted while busy");

  // A new result only appears out of the done state
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_DONE))
    else $error("result valid raised outside done state");

endmodule
`default_nettype wire

>>> hdl/rational_arithmetic_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Multiplies, adds, subtracts or divides two signed fractions and returns
// the result reduced to lowest terms with a positive denominator.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake            Contents
//  s_*      in   s_tvalid / s_tready  cmd, num_a, den_a, num_b, den_b
//  m_*      out  m_tvalid / m_tready  res_num, res_den; div_zero in tuser
//
//  One item at a time. An item takes an accept step, two or three products
//  (one shared multiplier), a sum, binary GCD steps and one restoring divide
//  step per quotient bit, MW = 2*OPERAND_WIDTH bits, then the output register.
//  Zero-denominator and divide-by-zero items skip the products, sum, GCD and
//  divide and go straight to the output register.
//  rst is synchronous and clears the controller; a result waiting in the
//  output register does not block accepting the next item.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit #(
  parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst,
  input  wire logic                                      s_tvalid,
  output logic                                           s_tready,
  // cmd, num_a, den_a, num_b, den_b (lowest bit up), zero padded
  input  wire logic [((rau_pkg::CMD_W + 4 * OPERAND_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
  output logic                                           m_tvalid,
  input  wire logic                                      m_tready,
  // res_num, res_den (lowest bit up)
  output logic [rau_pkg::NUM_W + rau_pkg::DEN_W - 1:0]   m_tdata,
  // div_zero
  output logic                                           m_tuser
);

  localparam int W = OPERAND_WIDTH;
  localparam int C = rau_pkg::CMD_W;

  // Input field unpacking
  logic [C-1:0]  cmd;
  logic [W-1:0]  num_a, den_a, num_b, den_b;

  assign cmd   = s_tdata[C-1:0];
  assign num_a = s_tdata[C + W - 1:C];
  assign den_a = s_tdata[C + 2 * W - 1:C + W];
  assign num_b = s_tdata[C + 3 * W - 1:C + 2 * W];
  assign den_b = s_tdata[C + 4 * W - 1:C + 3 * W];

  rau_pkg::dp_op_t             op;
  rau_pkg::dp_stat_t           stat;
  logic [rau_pkg::NUM_W-1:0]   res_num;
  logic [rau_pkg::DEN_W-1:0]   res_den;
  logic                        div_zero;

  rau_ctrl #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .op       (op)
  );

  rau_dpath #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .op       (op),
    .cmd      (cmd),
    .num_a    (num_a),
    .den_a    (den_a),
    .num_b    (num_b),
    .den_b    (den_b),
    .stat     (stat),
    .res_num  (res_num),
    .res_den  (res_den),
    .div_zero (div_zero)
  );

  // Result packing
  assign m_tdata = {res_den, res_num};
  assign m_tuser = div_zero;

endmodule
`default_nettype wire

>>> sim/rational_arithmetic_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit testbench
// Drives fraction pairs with all four operations into the stream input and
// checks each reduced result against a hand-written value or an in-bench
// calculator: a directed table of extremes and error items first, then
// random items under several sender-gap and receiver-stall mixes, including
// one long receiver hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_tb;

  localparam int OW              = 16;
  localparam int NW              = rau_pkg::NUM_W;
  localparam int DW              = rau_pkg::DEN_W;
  localparam int S_W             = ((rau_pkg::CMD_W + 4 * OW + 7) / 8) * 8;
  localparam int CLK_PERIOD      = 10;
  localparam int RESET_CYCLES    = 7;
  localparam int PRESSURE_ITEMS  = 24;
  localparam int HOLD_CYCLES     = 500;
  localparam int ITEMS_PER_PHASE = 475;
  localparam int DRAIN_CYCLES    = 250;
  localparam int IDLE_LIMIT      = 4000;

  // One input item: operation and two fractions
  typedef struct {
    rau_pkg::cmd_t         op;
    logic signed [OW-1:0]  na;
    logic signed [OW-1:0]  da;
    logic signed [OW-1:0]  nb;
    logic signed [OW-1:0]  db;
  } operands_t;

  // One result item
  typedef struct {
    logic signed [NW-1:0] num;
    logic [DW-1:0]        den;
    logic                 div_zero;
  } fraction_t;

  // Directed row; fixed rows carry a hand-written result
  typedef struct {
    operands_t opnd;
    bit        fixed;
    fraction_t want;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [S_W-1:0] s_tdata;  // cmd, num_a, den_a, num_b, den_b, zero pad
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [NW+DW-1:0] m_tdata;  // res_num, res_den
  logic m_tuser;              // div_zero

  fraction_t     pending_results[$];
  directed_row_t directed_rows[$];
  int            error_count = 0;
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;
  bit            hold_request = 1'b0;
  int            hold_left = 0;
  int            idle_cycles = 0;

  rational_arithmetic_unit #(
    .OPERAND_WIDTH(OW)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Exact fraction arithmetic, then reduction by the greatest common divisor
  function automatic fraction_t reduce_fraction(operands_t x);
    longint    na, da, nb, db, n, d, a, b, t;
    fraction_t r;
    na = x.na;
    da = x.da;
    nb = x.nb;
    db = x.db;
    r.num      = '0;
    r.den      = DW'(1);
    r.div_zero = 1'b1;
    if (da == 0 || db == 0 || (x.op == rau_pkg::CMD_DIV && nb == 0))
      return r;
    case (x.op)
      rau_pkg::CMD_MUL: begin
        n = na * nb;
        d = da * db;
      end
      rau_pkg::CMD_DIV: begin
        n = na * db;
        d = da * nb;
      end
      rau_pkg::CMD_ADD: begin
        n = na * db + nb * da;
        d = da * db;
      end
      default: begin
        n = na * db - nb * da;
        d = da * db;
      end
    endcase
    // sign lives in the numerator
    if (d < 0) begin
      n = -n;
      d = -d;
    end
    a = (n < 0) ? -n : n;
    b = d;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    r.num      = NW'(n / a);
    r.den      = DW'(d / a);
    r.div_zero = 1'b0;
    return r;
  endfunction

  function automatic void add_row(rau_pkg::cmd_t op, int na, int da, int nb, int db,
                                  bit fixed = 0, longint num = 0, longint den = 1,
                                  bit dz = 0);
    directed_row_t row;
    row.opnd.op       = op;
    row.opnd.na       = OW'(na);
    row.opnd.da       = OW'(da);
    row.opnd.nb       = OW'(nb);
    row.opnd.db       = OW'(db);
    row.fixed         = fixed;
    row.want.num      = NW'(num);
    row.want.den      = DW'(den);
    row.want.div_zero = dz;
    directed_rows.push_back(row);
  endfunction

  // Field value biased toward extremes, zero and small values (common factors)
  function automatic logic signed [OW-1:0] pick_field(bit is_den);
    logic signed [OW-1:0] v;
    int                   s;
    if (is_den && $urandom_range(39) == 0)
      return '0;
    case ($urandom_range(15))
      0: v = {1'b1, {(OW-1){1'b0}}};
      1: v = {1'b0, {(OW-1){1'b1}}};
      2: v = is_den ? '1 : '0;
      3, 4, 5, 6: begin
        s = int'($urandom_range(48));
        v = OW'(s - 24);
      end
      default: v = OW'($urandom);
    endcase
    return v;
  endfunction

  function automatic operands_t random_operands();
    operands_t x;
    x.op = rau_pkg::cmd_t'($urandom_range(3));
    x.na = pick_field(1'b0);
    x.da = pick_field(1'b1);
    x.nb = pick_field(1'b0);
    x.db = pick_field(1'b1);
    return x;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    error_count++;
  endtask

  // Offer one item, with an optional random gap in front; log its expected result
  task automatic send_operands(operands_t x, bit fixed, fraction_t want);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= S_W'({x.db, x.nb, x.da, x.na, x.op});
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(fixed ? want : reduce_fraction(x));
  endtask

  // Receiver: random stalls, or a counted hold-off when requested
  always @(posedge clk) begin
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare each result item with the oldest expectation
  always @(posedge clk) begin : result_check
    fraction_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.num      = m_tdata[NW-1:0];
      got.den      = m_tdata[NW+DW-1:NW];
      got.div_zero = m_tuser;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %0d/%0d with no item outstanding",
                                  got.num, got.den));
      end else begin
        want = pending_results.pop_front();
        if (got.num !== want.num)
          report_mismatch($sformatf("res_num %0d, expected %0d", got.num, want.num));
        if (got.den !== want.den)
          report_mismatch($sformatf("res_den %0d, expected %0d", got.den, want.den));
        if (got.div_zero !== want.div_zero)
          report_mismatch($sformatf("div_zero %b, expected %b",
                                    got.div_zero, want.div_zero));
      end
    end
  end

  // Watchdog: too long without any item moving on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("rational_arithmetic_unit verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    fraction_t none;
    int        phase;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    none.num      = '0;
    none.den      = DW'(1);
    none.div_zero = 1'b0;

    // first row right after reset, then extremes, errors and mixed signs
    add_row(rau_pkg::CMD_MUL,      1,      1,      1,      1, 1, 1, 1, 0);
    add_row(rau_pkg::CMD_MUL,      0,      5,      3,      7, 1, 0, 1, 0);
    add_row(rau_pkg::CMD_DIV,      3,      4,      0,      5, 1, 0, 1, 1);
    add_row(rau_pkg::CMD_ADD,      1,      0,      1,      1, 1, 0, 1, 1);
    add_row(rau_pkg::CMD_SUB,      1,      1,      1,      0, 1, 0, 1, 1);
    add_row(rau_pkg::CMD_MUL,      0,      0,      0,      0, 1, 0, 1, 1);
    add_row(rau_pkg::CMD_DIV,      5,      3,      7,      0, 1, 0, 1, 1);
    add_row(rau_pkg::CMD_DIV, -32768,      0, -32768,      0, 1, 0, 1, 1);
    add_row(rau_pkg::CMD_MUL, -32768,      1, -32768,      1, 1, 1073741824, 1, 0);
    add_row(rau_pkg::CMD_ADD, -32768,      1, -32768,      1, 1, -65536, 1, 0);
    add_row(rau_pkg::CMD_DIV,      1,     -1,     -1,      1, 1, 1, 1, 0);
    add_row(rau_pkg::CMD_SUB,      5,      3,      5,      3, 1, 0, 1, 0);
    add_row(rau_pkg::CMD_DIV,      0,      1,      5,      7, 1, 0, 1, 0);
    add_row(rau_pkg::CMD_ADD,  32767, -32768,  32767, -32768);
    add_row(rau_pkg::CMD_SUB, -32768,  32767,  32767, -32768);
    add_row(rau_pkg::CMD_DIV, -32768,  32767,  32767, -32768);
    add_row(rau_pkg::CMD_MUL,  32767, -32768,  32767, -32768);
    add_row(rau_pkg::CMD_ADD, -32768, -32768,  32767,  32767);
    add_row(rau_pkg::CMD_DIV,     -1, -32768, -32768,     -1);
    add_row(rau_pkg::CMD_ADD,      1,      2,      1,      2);
    add_row(rau_pkg::CMD_SUB,      6,     -4,     -9,      6);
    add_row(rau_pkg::CMD_MUL,     12,     18,     -6,      4);
    add_row(rau_pkg::CMD_DIV,      7,      3, -32768,      1);
    add_row(rau_pkg::CMD_MUL,     -1,     -1,     -1,     -1);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_operands(directed_rows[i].opnd, directed_rows[i].fixed, directed_rows[i].want);

    // long receiver hold-off while items keep coming
    hold_request = 1'b1;
    repeat (PRESSURE_ITEMS) send_operands(random_operands(), 1'b0, none);

    // random items under each idling mix
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 82;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 82;
        end
        default: begin
          send_idle_pct  = 12;
          recv_stall_pct = 12;
        end
      endcase
      repeat (ITEMS_PER_PHASE) send_operands(random_operands(), 1'b0, none);
    end
    s_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0)
      $display("rational_arithmetic_unit verification clean");
    else
      $display("rational_arithmetic_unit verification failed");
    $finish;
  end

endmodule

>>> filelist.f
hdl/rau_pkg.sv
hdl/rau_dpath.sv
hdl/rau_ctrl.sv
hdl/rational_arithmetic_unit.sv
sim/rational_arithmetic_unit_tb.sv
